// File: sv/mdio_pm_pkg.sv
// ----------------------------------------------------------------------------
// MDIO register master package
// Shared types, codes and frame helpers of the MDIO register master.
// ----------------------------------------------------------------------------
`default_nettype none

package mdio_pm_pkg;

   // Request function codes.
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREAMBLE_LEN     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TURNAROUND_LIMIT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MMD_SPLIT_ADDR   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MMD_DEV_LOW      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MMD_DEV_HIGH     = 3'd4;

   // Configuration reset values.
   localparam logic [5:0]  PREAMBLE_LEN_RST     = 6'd32;
   localparam logic [5:0]  TURNAROUND_LIMIT_RST = 6'd32;
   localparam logic [15:0] MMD_SPLIT_ADDR_RST   = 16'h0fff;
   localparam logic [4:0]  MMD_DEV_LOW_RST      = 5'h1f;
   localparam logic [4:0]  MMD_DEV_HIGH_RST     = 5'h01;

   // Sequencer phase codes.
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_PRE     = 3'd1;
   localparam logic [2:0] PH_HDR     = 3'd2;
   localparam logic [2:0] PH_WDATA   = 3'd3;
   localparam logic [2:0] PH_WAIT    = 3'd4;
   localparam logic [2:0] PH_RDATA   = 3'd5;
   localparam logic [2:0] PH_REST    = 3'd6;
   localparam logic [2:0] PH_REST_TO = 3'd7;

   // Extended access register numbers and flags.
   localparam logic [4:0]  CTRL_REG      = 5'h0d;
   localparam logic [4:0]  ADDR_REG      = 5'h0e;
   localparam logic [15:0] MMD_DATA_FLAG = 16'h4000;
   localparam logic [15:0] DIRECT_MAX    = 16'h001f;
   localparam logic [1:0]  LAST_FRAME    = 2'd3;
   localparam logic [5:0]  DATA_BITS     = 6'd16;
   localparam logic [5:0]  READ_HDR_BITS = 6'd14;

   typedef struct packed {
      logic [5:0]  preamble_len;
      logic [5:0]  turnaround_limit;
      logic [15:0] mmd_split_addr;
      logic [4:0]  mmd_dev_low;
      logic [4:0]  mmd_dev_high;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [4:0]  phy_addr;
      logic [15:0] reg_addr;
      logic [15:0] write_data;
      logic        mdio_in;
   } req_payload_type;

   typedef struct packed {
      logic        mdc_pulse;
      logic        mdio_drive;
      logic        mdio_enable;
      logic        busy_res;
      logic        done_res;
      logic [15:0] read_data;
      logic        timed_out;
      logic        rejected;
   } rsp_payload_type;

   typedef struct packed {
      logic [4:0]  reg5;
      logic [15:0] word;
      logic        is_read;
   } frame_spec_type;

   typedef struct packed {
      logic [15:0] word;
      logic [5:0]  count;
   } frame_hdr_type;

   // Register number, data word and direction of one frame of a transaction.
   function automatic frame_spec_type frame_spec(
      input logic        extended,
      input logic [1:0]  frame_index,
      input logic [15:0] reg_addr,
      input logic [15:0] data,
      input logic [4:0]  device,
      input logic        is_write
   );
      frame_spec_type spec;
      spec.is_read = 1'b0;
      if (!extended) begin
         spec.reg5    = reg_addr[4:0];
         spec.word    = data;
         spec.is_read = !is_write;
      end else begin
         unique case (frame_index)
            2'd0: begin
               spec.reg5 = CTRL_REG;
               spec.word = {11'd0, device};
            end
            2'd1: begin
               spec.reg5 = ADDR_REG;
               spec.word = reg_addr;
            end
            2'd2: begin
               spec.reg5 = CTRL_REG;
               spec.word = MMD_DATA_FLAG | {11'd0, device};
            end
            default: begin
               spec.reg5    = ADDR_REG;
               spec.word    = data;
               spec.is_read = !is_write;
            end
         endcase
      end
      return spec;
   endfunction

   // Header bits sent MSB first: start, opcode, PHY, register and, for a
   // write, the driven turnaround.
   function automatic frame_hdr_type frame_header(
      input frame_spec_type spec,
      input logic [4:0]     phy
   );
      frame_hdr_type hdr;
      if (spec.is_read) begin
         hdr.word  = {2'b00, 2'b01, 2'b10, phy, spec.reg5};
         hdr.count = READ_HDR_BITS;
      end else begin
         hdr.word  = {2'b01, 2'b01, phy, spec.reg5, 2'b10};
         hdr.count = DATA_BITS;
      end
      return hdr;
   endfunction

endpackage

`default_nettype wire

// File: sv/mdio_pm_if.sv
// ----------------------------------------------------------------------------
// MDIO register master channels
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdio_pm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [4:0]  phy_addr;
   logic [15:0] reg_addr;
   logic [15:0] write_data;
   logic        mdio_in;

   modport source (output valid, func, phy_addr, reg_addr, write_data, mdio_in,
                   input ready);
   modport sink (input valid, func, phy_addr, reg_addr, write_data, mdio_in,
                 output ready);
endinterface

interface mdio_pm_rsp_if;
   logic        valid;
   logic        ready;
   logic        mdc_pulse;
   logic        mdio_drive;
   logic        mdio_enable;
   logic        busy_res;
   logic        done_res;
   logic [15:0] read_data;
   logic        timed_out;
   logic        rejected;

   modport source (output valid, mdc_pulse, mdio_drive, mdio_enable, busy_res,
                   done_res, read_data, timed_out, rejected,
                   input ready);
   modport sink (input valid, mdc_pulse, mdio_drive, mdio_enable, busy_res,
                 done_res, read_data, timed_out, rejected,
                 output ready);
endinterface

`default_nettype wire

// File: sv/mdio_pm_engine.sv
// ----------------------------------------------------------------------------
// MDIO register master frame engine
// Holds the frame sequencer state and advances it by one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module mdio_pm_engine (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire mdio_pm_pkg::req_payload_type req,
   input  wire mdio_pm_pkg::cfg_type         cfg,
   output mdio_pm_pkg::rsp_payload_type      rsp
);

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  frame_index_ff, frame_index_in;
   logic [5:0]  bit_count_ff, bit_count_in;
   logic [15:0] tx_shift_ff, tx_shift_in;
   logic [15:0] rx_shift_ff, rx_shift_in;
   logic [5:0]  wait_count_ff, wait_count_in;
   logic [4:0]  held_phy_ff, held_phy_in;
   logic [15:0] held_reg_ff, held_reg_in;
   logic [15:0] held_data_ff, held_data_in;
   logic        held_write_ff, held_write_in;
   logic        held_extended_ff, held_extended_in;
   logic [4:0]  held_device_ff, held_device_in;

   mdio_pm_pkg::frame_spec_type spec_req, spec_cur, spec_nxt, spec_start;
   mdio_pm_pkg::frame_hdr_type  hdr_start, hdr_cur;
   logic        req_extended;
   logic [4:0]  req_device;
   logic [1:0]  frame_next;
   logic [5:0]  bit_dec;
   logic [3:0]  bit_sel;
   logic        start_frame;
   logic [4:0]  start_phy;

   // Frame descriptions for a new request, the current frame and the next one.
   assign req_extended = req.reg_addr > mdio_pm_pkg::DIRECT_MAX;
   assign req_device   = (req.reg_addr <= cfg.mmd_split_addr) ? cfg.mmd_dev_low
                                                             : cfg.mmd_dev_high;
   assign frame_next   = frame_index_ff + 2'd1;
   assign spec_req = mdio_pm_pkg::frame_spec(req_extended, 2'd0, req.reg_addr,
                                             req.write_data, req_device,
                                             req.func == mdio_pm_pkg::FUNC_WRITE);
   assign spec_cur = mdio_pm_pkg::frame_spec(held_extended_ff, frame_index_ff,
                                             held_reg_ff, held_data_ff,
                                             held_device_ff, held_write_ff);
   assign spec_nxt = mdio_pm_pkg::frame_spec(held_extended_ff, frame_next,
                                             held_reg_ff, held_data_ff,
                                             held_device_ff, held_write_ff);
   assign hdr_cur  = mdio_pm_pkg::frame_header(spec_cur, held_phy_ff);

   // A frame starts on a request or after a non-final extended write frame.
   assign start_phy = (phase_ff == mdio_pm_pkg::PH_IDLE) ? req.phy_addr : held_phy_ff;
   assign spec_start = (phase_ff == mdio_pm_pkg::PH_IDLE) ? spec_req : spec_nxt;
   assign hdr_start  = mdio_pm_pkg::frame_header(spec_start, start_phy);

   assign bit_dec = (bit_count_ff != 6'd0) ? bit_count_ff - 6'd1 : 6'd0;
   assign bit_sel = bit_dec[3:0];

   // Next state and the result of this transaction.
   always_comb begin
      phase_in         = phase_ff;
      frame_index_in   = frame_index_ff;
      bit_count_in     = bit_count_ff;
      tx_shift_in      = tx_shift_ff;
      rx_shift_in      = rx_shift_ff;
      wait_count_in    = wait_count_ff;
      held_phy_in      = held_phy_ff;
      held_reg_in      = held_reg_ff;
      held_data_in     = held_data_ff;
      held_write_in    = held_write_ff;
      held_extended_in = held_extended_ff;
      held_device_in   = held_device_ff;
      start_frame      = 1'b0;

      rsp = '0;
      rsp.mdio_drive  = 1'b1;
      rsp.mdio_enable = 1'b1;

      if (req.func == mdio_pm_pkg::FUNC_READ || req.func == mdio_pm_pkg::FUNC_WRITE) begin
         if (phase_ff != mdio_pm_pkg::PH_IDLE) begin
            rsp.rejected = 1'b1;
         end else begin
            held_phy_in      = req.phy_addr;
            held_reg_in      = req.reg_addr;
            held_data_in     = req.write_data;
            held_write_in    = req.func == mdio_pm_pkg::FUNC_WRITE;
            held_extended_in = req_extended;
            held_device_in   = req_device;
            frame_index_in   = 2'd0;
            wait_count_in    = 6'd0;
            rx_shift_in      = 16'd0;
            start_frame      = 1'b1;
         end
      end else if (req.func == mdio_pm_pkg::FUNC_TICK) begin
         unique case (phase_ff)
            mdio_pm_pkg::PH_PRE, mdio_pm_pkg::PH_HDR, mdio_pm_pkg::PH_WDATA: begin
               rsp.mdc_pulse = 1'b1;
               if (phase_ff != mdio_pm_pkg::PH_PRE && bit_count_ff != 6'd0) begin
                  rsp.mdio_drive = tx_shift_ff[bit_sel];
               end
               bit_count_in = bit_dec;
               if (bit_dec == 6'd0) begin
                  priority if (phase_ff == mdio_pm_pkg::PH_PRE) begin
                     phase_in     = mdio_pm_pkg::PH_HDR;
                     tx_shift_in  = hdr_cur.word;
                     bit_count_in = hdr_cur.count;
                  end else if (phase_ff == mdio_pm_pkg::PH_HDR) begin
                     if (spec_cur.is_read) begin
                        phase_in      = mdio_pm_pkg::PH_WAIT;
                        wait_count_in = 6'd0;
                     end else begin
                        phase_in     = mdio_pm_pkg::PH_WDATA;
                        tx_shift_in  = spec_cur.word;
                        bit_count_in = mdio_pm_pkg::DATA_BITS;
                     end
                  end else if (held_extended_ff &&
                               frame_index_ff != mdio_pm_pkg::LAST_FRAME) begin
                     frame_index_in = frame_next;
                     start_frame    = 1'b1;
                  end else begin
                     phase_in     = mdio_pm_pkg::PH_IDLE;
                     rsp.done_res = 1'b1;
                  end
               end
            end
            mdio_pm_pkg::PH_WAIT: begin
               rsp.mdc_pulse   = 1'b1;
               rsp.mdio_enable = 1'b0;
               rsp.mdio_drive  = 1'b0;
               priority if (!req.mdio_in) begin
                  phase_in     = mdio_pm_pkg::PH_RDATA;
                  bit_count_in = mdio_pm_pkg::DATA_BITS;
                  rx_shift_in  = 16'd0;
               end else if (wait_count_ff >= cfg.turnaround_limit) begin
                  phase_in = mdio_pm_pkg::PH_REST_TO;
               end else begin
                  wait_count_in = wait_count_ff + 6'd1;
               end
            end
            mdio_pm_pkg::PH_RDATA: begin
               rsp.mdc_pulse   = 1'b1;
               rsp.mdio_enable = 1'b0;
               rsp.mdio_drive  = 1'b0;
               rx_shift_in     = {rx_shift_ff[14:0], req.mdio_in};
               bit_count_in    = bit_dec;
               if (bit_dec == 6'd0) begin
                  phase_in = mdio_pm_pkg::PH_REST;
               end
            end
            mdio_pm_pkg::PH_REST, mdio_pm_pkg::PH_REST_TO: begin
               rsp.mdc_pulse = 1'b1;
               rsp.done_res  = 1'b1;
               if (phase_ff == mdio_pm_pkg::PH_REST) begin
                  rsp.read_data = rx_shift_ff;
               end else begin
                  rsp.timed_out = 1'b1;
               end
               phase_in = mdio_pm_pkg::PH_IDLE;
            end
            default: begin
               phase_in = mdio_pm_pkg::PH_IDLE;
            end
         endcase
      end

      // Frame start: preamble first, or straight into the header.
      if (start_frame) begin
         if (cfg.preamble_len != 6'd0) begin
            phase_in     = mdio_pm_pkg::PH_PRE;
            bit_count_in = cfg.preamble_len;
         end else begin
            phase_in     = mdio_pm_pkg::PH_HDR;
            tx_shift_in  = hdr_start.word;
            bit_count_in = hdr_start.count;
         end
      end

      rsp.busy_res = phase_in != mdio_pm_pkg::PH_IDLE;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= mdio_pm_pkg::PH_IDLE;
         frame_index_ff <= 2'd0;
         bit_count_ff   <= 6'd0;
         wait_count_ff  <= 6'd0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         frame_index_ff <= frame_index_in;
         bit_count_ff   <= bit_count_in;
         wait_count_ff  <= wait_count_in;
      end
   end

   // Shift registers and the held request.
   always_ff @(posedge clock) begin
      if (accept) begin
         tx_shift_ff      <= tx_shift_in;
         rx_shift_ff      <= rx_shift_in;
         held_phy_ff      <= held_phy_in;
         held_reg_ff      <= held_reg_in;
         held_data_ff     <= held_data_in;
         held_write_ff    <= held_write_in;
         held_extended_ff <= held_extended_in;
         held_device_ff   <= held_device_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/mdio_phy_register_master.sv
// ----------------------------------------------------------------------------
// MDIO PHY register master
// Clause-22 master with clause-45 indirect access, one bit period per tick.
// ----------------------------------------------------------------------------
// Every request transaction and every tick transaction yields exactly one
// response transaction in the cycle after it is accepted. The work for a
// transaction is one registered pass through the frame engine, so a new
// transaction can be accepted in every clock cycle while responses are taken.
// The response register stalls the input only while a response waits and
// rsp_chan.ready is low; in the cycle the waiting response is taken, the next
// transaction is accepted. Read and write requests are latched; each following
// tick moves the MDC/MDIO frame by one bit period. A request that arrives while
// a transaction is in progress is answered with rejected set. The user must
// write csr configuration only while the master is idle; no check enforces it.
`default_nettype none

module mdio_phy_register_master (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   mdio_pm_req_if.sink                                req_chan,
   mdio_pm_rsp_if.source                              rsp_chan,
   input  wire logic                                  csr_write_en,
   input  wire logic [mdio_pm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [mdio_pm_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   mdio_pm_pkg::cfg_type         cfg_ff;
   mdio_pm_pkg::req_payload_type req_payload;
   mdio_pm_pkg::rsp_payload_type rsp_result;
   mdio_pm_pkg::rsp_payload_type rsp_data_ff;
   logic                         rsp_valid_ff;
   logic                         accept;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preamble_len     <= mdio_pm_pkg::PREAMBLE_LEN_RST;
         cfg_ff.turnaround_limit <= mdio_pm_pkg::TURNAROUND_LIMIT_RST;
         cfg_ff.mmd_split_addr   <= mdio_pm_pkg::MMD_SPLIT_ADDR_RST;
         cfg_ff.mmd_dev_low      <= mdio_pm_pkg::MMD_DEV_LOW_RST;
         cfg_ff.mmd_dev_high     <= mdio_pm_pkg::MMD_DEV_HIGH_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            mdio_pm_pkg::CSR_PREAMBLE_LEN:
               cfg_ff.preamble_len <= csr_write_data[5:0];
            mdio_pm_pkg::CSR_TURNAROUND_LIMIT:
               cfg_ff.turnaround_limit <= csr_write_data[5:0];
            mdio_pm_pkg::CSR_MMD_SPLIT_ADDR:
               cfg_ff.mmd_split_addr <= csr_write_data;
            mdio_pm_pkg::CSR_MMD_DEV_LOW:
               cfg_ff.mmd_dev_low <= csr_write_data[4:0];
            mdio_pm_pkg::CSR_MMD_DEV_HIGH:
               cfg_ff.mmd_dev_high <= csr_write_data[4:0];
            default: begin
            end
         endcase
      end
   end

   // Input side: accept whenever the response register is free or draining.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign req_payload.func       = req_chan.func;
   assign req_payload.phy_addr   = req_chan.phy_addr;
   assign req_payload.reg_addr   = req_chan.reg_addr;
   assign req_payload.write_data = req_chan.write_data;
   assign req_payload.mdio_in    = req_chan.mdio_in;

   mdio_pm_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .cfg    (cfg_ff),
      .rsp    (rsp_result)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_result;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.mdc_pulse   = rsp_data_ff.mdc_pulse;
   assign rsp_chan.mdio_drive  = rsp_data_ff.mdio_drive;
   assign rsp_chan.mdio_enable = rsp_data_ff.mdio_enable;
   assign rsp_chan.busy_res    = rsp_data_ff.busy_res;
   assign rsp_chan.done_res    = rsp_data_ff.done_res;
   assign rsp_chan.read_data   = rsp_data_ff.read_data;
   assign rsp_chan.timed_out   = rsp_data_ff.timed_out;
   assign rsp_chan.rejected    = rsp_data_ff.rejected;

endmodule

`default_nettype wire

// File: sv/mdio_pm_checker.sv
// ----------------------------------------------------------------------------
// MDIO register master checker
// Port-level checks on response transactions of the MDIO register master.
// ----------------------------------------------------------------------------
`default_nettype none

module mdio_pm_props (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        mdc_pulse,
   input wire logic        mdio_drive,
   input wire logic        mdio_enable,
   input wire logic        busy_res,
   input wire logic        done_res,
   input wire logic [15:0] read_data,
   input wire logic        timed_out,
   input wire logic        rejected
);

   // A finished transaction leaves the master idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> !busy_res)
      else $error("done reported while still busy");

   // Only a busy master rejects a request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rejected |-> busy_res && !mdc_pulse && !done_res)
      else $error("reject without a transaction in progress");

   // A timeout ends the read with zero data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && timed_out |-> done_res && read_data == 16'd0 && mdc_pulse)
      else $error("timeout result malformed");

   // The line is only released in clocked turnaround or read bit periods.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !mdio_enable |-> mdc_pulse && !mdio_drive && busy_res)
      else $error("line released outside a read period");

   // A stalled response stays valid with read data and done flag held.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data) && $stable(done_res))
      else $error("stalled response changed");

endmodule

bind mdio_phy_register_master mdio_pm_props u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .mdc_pulse   (rsp_chan.mdc_pulse),
   .mdio_drive  (rsp_chan.mdio_drive),
   .mdio_enable (rsp_chan.mdio_enable),
   .busy_res    (rsp_chan.busy_res),
   .done_res    (rsp_chan.done_res),
   .read_data   (rsp_chan.read_data),
   .timed_out   (rsp_chan.timed_out),
   .rejected    (rsp_chan.rejected)
);

`default_nettype wire
